FILE: sv/utf8d_pkg.sv
package utf8d_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned CP_W     = 21;

    // Decode status codes, as they appear on the result port
    localparam logic [STATUS_W-1:0] ST_START  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ACCEPT = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EXP1   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EXP2   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_EXP3   = 3'd5;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CP_W-1:0]     acc;
    } dec_state_t;

endpackage

FILE: sv/utf8d_step.sv
module utf8d_step (
    input  utf8d_pkg::dec_state_t         cur,
    input  logic [utf8d_pkg::BYTE_W-1:0]  byte_in,
    output utf8d_pkg::dec_state_t         nxt
);

    logic                            is_cont;
    logic [utf8d_pkg::CP_W-1:0]      tail_bits;
    logic [utf8d_pkg::STATUS_W-1:0]  tail_status;

    assign is_cont = (byte_in[7:6] == 2'b10);

    always_comb begin
        nxt         = cur;
        tail_bits   = '0;
        tail_status = utf8d_pkg::ST_REJECT;
        case (cur.status)
            utf8d_pkg::ST_START,
            utf8d_pkg::ST_ACCEPT,
            utf8d_pkg::ST_REJECT: begin
                if (byte_in == 8'hC0 || byte_in == 8'hC1) begin
                    nxt.status = utf8d_pkg::ST_REJECT;
                end else if (byte_in[7] == 1'b0) begin
                    nxt.acc    = {13'd0, byte_in};
                    nxt.status = utf8d_pkg::ST_ACCEPT;
                end else if (is_cont) begin
                    // stray continuation: resync
                    nxt.status = utf8d_pkg::ST_START;
                end else if (byte_in[7:5] == 3'b110) begin
                    nxt.acc    = {10'd0, byte_in[4:0], 6'd0};
                    nxt.status = utf8d_pkg::ST_EXP1;
                end else if (byte_in[7:4] == 4'b1110) begin
                    nxt.acc    = {5'd0, byte_in[3:0], 12'd0};
                    nxt.status = utf8d_pkg::ST_EXP2;
                end else if (byte_in[7:3] == 5'b11110) begin
                    nxt.acc    = {byte_in[2:0], 18'd0};
                    nxt.status = utf8d_pkg::ST_EXP3;
                end else begin
                    nxt.status = utf8d_pkg::ST_REJECT;
                end
            end
            utf8d_pkg::ST_EXP3: begin
                tail_bits   = {3'd0, byte_in[5:0], 12'd0};
                tail_status = is_cont ? utf8d_pkg::ST_EXP2 : utf8d_pkg::ST_REJECT;
                nxt.acc     = cur.acc | tail_bits;
                nxt.status  = tail_status;
            end
            utf8d_pkg::ST_EXP2: begin
                tail_bits   = {9'd0, byte_in[5:0], 6'd0};
                tail_status = is_cont ? utf8d_pkg::ST_EXP1 : utf8d_pkg::ST_REJECT;
                nxt.acc     = cur.acc | tail_bits;
                nxt.status  = tail_status;
            end
            utf8d_pkg::ST_EXP1: begin
                tail_bits   = {15'd0, byte_in[5:0]};
                tail_status = is_cont ? utf8d_pkg::ST_ACCEPT : utf8d_pkg::ST_REJECT;
                nxt.acc     = cur.acc | tail_bits;
                nxt.status  = tail_status;
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

endmodule

FILE: sv/utf8_byte_decoder.sv
// UTF-8 byte decoder. Feed one byte of the stream per word on the s_ channel; every
// byte gives exactly one result word on the m_ channel carrying the new decode status
// (0 start, 1 accept, 2 reject, 3/4/5 expecting one/two/three more bytes) and the 21-bit
// code-point accumulator, which holds a finished code point when the status is accept.
// Lead bytes C0, C1 and F8..FF reject, a stray continuation byte resyncs to start, and a
// non-continuation byte where a continuation is due rejects after its low six bits have
// been merged. Surrogates, overlong 3/4-byte forms and values above 10FFFF pass unchecked.
// Throughput is one byte per clock while the result side does not stall: the decode
// step is a single level of compare and merge logic between the input register and the
// result register, and the status and accumulator it updates feed straight back to it.
// Each byte waits in the input register and its result word is loaded into the result
// register. The output register holds a result while m_ready is low, and the input
// register keeps taking a byte whenever the result register can move on.
module utf8_byte_decoder (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [utf8d_pkg::BYTE_W-1:0]        s_byte_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [utf8d_pkg::STATUS_W-1:0]      m_status,
    output logic [utf8d_pkg::CP_W-1:0]          m_code_point
);

    // input register
    logic                               in_valid_reg;
    logic [utf8d_pkg::BYTE_W-1:0]       in_byte_reg;

    // decoder state
    utf8d_pkg::dec_state_t              state_reg;
    utf8d_pkg::dec_state_t              state_next;

    // result register
    logic                               out_valid_reg;
    utf8d_pkg::dec_state_t              out_reg;

    logic                               advance;

    // Move the held byte through the decode step when the result register is free
    // or is being emptied in this cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    utf8d_step u_step (
        .cur     (state_reg),
        .byte_in (in_byte_reg),
        .nxt     (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_in;
        end
    end

    // Decode status and accumulator: control state, so reset both.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.status <= utf8d_pkg::ST_START;
            state_reg.acc    <= '0;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload of the result word: load alongside the state update.
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= state_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_status     = out_reg.status;
    assign m_code_point = out_reg.acc;

`ifndef SYNTHESIS
    // A word that enters the decode step always lands in the result register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("decoded word lost before result register");

    // A byte blocked by a full result register waits unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("held input byte dropped or altered");

    // The word on show always matches the live decoder state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (m_status == state_reg.status && m_code_point == state_reg.acc))
        else $error("result word out of step with decoder state");

    // The two unused status codes are never entered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.status <= utf8d_pkg::ST_EXP3)
        else $error("decoder entered an unused status code");
`endif

endmodule

FILE: verif/utf8_byte_decoder_tb.sv
module utf8_byte_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 400;
    localparam int HOLD_AT      = 150;    // result count at which the receiver holds off
    localparam int HOLD_CYCLES  = 90;
    localparam int DRAIN_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 200000;

    typedef logic [utf8d_pkg::BYTE_W-1:0] byte_t;

    // Tracks the decode status and accumulator and keeps the words still owed by the block
    class decode_scoreboard;
        logic [utf8d_pkg::STATUS_W-1:0] cur_status;
        logic [utf8d_pkg::CP_W-1:0]     cur_acc;
        utf8d_pkg::dec_state_t          pending_words[$];
        int                             errors;
        int                             checked;
        int                             accepts;
        int                             rejects;
        int                             resyncs;

        function new();
            cur_status = utf8d_pkg::ST_START;
            cur_acc    = '0;
            errors     = 0;
            checked    = 0;
            accepts    = 0;
            rejects    = 0;
            resyncs    = 0;
        endfunction

        function int pending_count();
            return pending_words.size();
        endfunction

        // Advance the predicted state by one accepted byte and queue the word it must produce
        function void note_byte(byte_t din);
            utf8d_pkg::dec_state_t          exp_word;
            int                             shift;
            logic [utf8d_pkg::STATUS_W-1:0] next_status;
            shift       = 0;
            next_status = utf8d_pkg::ST_ACCEPT;
            case (cur_status)
                utf8d_pkg::ST_START, utf8d_pkg::ST_ACCEPT, utf8d_pkg::ST_REJECT: begin
                    if (din == 8'hC0 || din == 8'hC1) begin
                        cur_status = utf8d_pkg::ST_REJECT;
                    end else if (!din[7]) begin
                        cur_acc    = {13'd0, din};
                        cur_status = utf8d_pkg::ST_ACCEPT;
                    end else if (din[7:6] == 2'b10) begin
                        cur_status = utf8d_pkg::ST_START;
                    end else if (din[7:5] == 3'b110) begin
                        cur_acc    = {10'd0, din[4:0], 6'd0};
                        cur_status = utf8d_pkg::ST_EXP1;
                    end else if (din[7:4] == 4'b1110) begin
                        cur_acc    = {5'd0, din[3:0], 12'd0};
                        cur_status = utf8d_pkg::ST_EXP2;
                    end else if (din[7:3] == 5'b11110) begin
                        cur_acc    = {din[2:0], 18'd0};
                        cur_status = utf8d_pkg::ST_EXP3;
                    end else begin
                        cur_status = utf8d_pkg::ST_REJECT;
                    end
                end
                utf8d_pkg::ST_EXP3, utf8d_pkg::ST_EXP2, utf8d_pkg::ST_EXP1: begin
                    if (cur_status == utf8d_pkg::ST_EXP3) begin
                        shift       = 12;
                        next_status = utf8d_pkg::ST_EXP2;
                    end else if (cur_status == utf8d_pkg::ST_EXP2) begin
                        shift       = 6;
                        next_status = utf8d_pkg::ST_EXP1;
                    end
                    // merge first, then check the tag bits
                    cur_acc    = cur_acc | ({15'd0, din[5:0]} << shift);
                    cur_status = (din[7:6] == 2'b10) ? next_status : utf8d_pkg::ST_REJECT;
                end
                default: ;
            endcase
            if (cur_status == utf8d_pkg::ST_ACCEPT) accepts++;
            if (cur_status == utf8d_pkg::ST_REJECT) rejects++;
            if (cur_status == utf8d_pkg::ST_START)  resyncs++;
            exp_word.status = cur_status;
            exp_word.acc    = cur_acc;
            pending_words.push_back(exp_word);
        endfunction

        function void check_word(logic [utf8d_pkg::STATUS_W-1:0] status,
                                 logic [utf8d_pkg::CP_W-1:0] code_point);
            utf8d_pkg::dec_state_t exp_word;
            if (pending_words.size() == 0) begin
                $display("%0t: result word with nothing expected, status %0d code point %06h",
                         $time, status, code_point);
                errors++;
                return;
            end
            exp_word = pending_words.pop_front();
            checked++;
            if (status !== exp_word.status) begin
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, exp_word.status, status);
                errors++;
            end
            if (code_point !== exp_word.acc) begin
                $display("%0t: code point mismatch, expected %06h, got %06h",
                         $time, exp_word.acc, code_point);
                errors++;
            end
        endfunction
    endclass

    logic                           aclk      = 1'b0;
    logic                           aresetn   = 1'b0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    byte_t                          s_byte_in = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    logic [utf8d_pkg::STATUS_W-1:0] m_status;
    logic [utf8d_pkg::CP_W-1:0]     m_code_point;

    decode_scoreboard    sb = new();
    byte_t               stream[$];
    int                  cycles    = 0;
    int                  held_off  = 0;

    utf8_byte_decoder u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_byte_in    (s_byte_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_code_point (m_code_point)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Hard stop in case the block wedges or drops a word
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still owed", cycles, sb.pending_count());
            $display("utf8_byte_decoder_tb: FAIL");
            $finish;
        end
    end

    // Draw the idle count for one word; every fourth stretch of 32 words runs flat out
    function automatic int draw_wait(int idx);
        if ((idx / 32) % 4 == 3) return 0;
        return $urandom_range(0, 11);
    endfunction

    // Offer one byte, hold it until the block takes it, then note it in the scoreboard.
    // Valid is only lowered when a gap is drawn, so it never drops and rises in one step.
    task automatic drive_byte(byte_t din, int idx);
        int gap;
        gap = draw_wait(idx);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_byte_in <= din;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_byte(din);
    endtask

    // Receiver: draw a stall per word, with one long hold-off to fill the block and
    // back-pressure the sender. Outputs are sampled at the edge, before any update lands.
    initial begin
        int stall;
        int rx;
        rx = 0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (rx == HOLD_AT) begin
                stall    = HOLD_CYCLES;
                held_off = HOLD_CYCLES;
            end else begin
                stall = draw_wait(rx + 16);
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            sb.check_word(m_status, m_code_point);
            rx++;
        end
    end

    initial begin
        int pick;
        int len;
        int n_tail;
        int directed_n;

        // Directed part: ASCII extremes, the C0/C1 and F8..FF rejects, a stray continuation,
        // each sequence length at its top values, and bad tails that reject after merging.
        stream = '{8'h00, 8'h7F, 8'hC0, 8'hC1, 8'h80, 8'hF8, 8'hFF,
                   8'hC2, 8'h80, 8'hDF, 8'hBF,
                   8'hEF, 8'hBF, 8'hBF,
                   8'hF7, 8'hBF, 8'hBF, 8'hBF,
                   8'hE2, 8'h41,
                   8'hF0, 8'h90, 8'hC3,
                   8'h7F};
        directed_n = stream.size();

        // Random part: mostly well-formed sequences, the rest raw noise and cut-short sequences
        while (stream.size() < directed_n + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                len = $urandom_range(1, 4);
                case (len)
                    1: stream.push_back(byte_t'($urandom_range(8'h00, 8'h7F)));
                    2: stream.push_back(byte_t'($urandom_range(8'hC2, 8'hDF)));
                    3: stream.push_back(byte_t'($urandom_range(8'hE0, 8'hEF)));
                    default: stream.push_back(byte_t'($urandom_range(8'hF0, 8'hF7)));
                endcase
                repeat (len - 1) stream.push_back(8'h80 | byte_t'($urandom_range(0, 63)));
            end else if (pick < 9) begin
                stream.push_back(byte_t'($urandom));
            end else begin
                stream.push_back(byte_t'($urandom_range(8'hC2, 8'hF7)));
                n_tail = $urandom_range(0, 2);
                repeat (n_tail) stream.push_back(8'h80 | byte_t'($urandom_range(0, 63)));
                stream.push_back(byte_t'($urandom));
            end
        end

        // Hold reset, then release it once
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < stream.size(); i++) begin
            drive_byte(stream[i], i);
        end
        s_valid <= 1'b0;

        // Drain every owed word, then watch a little longer for strays
        while (sb.pending_count() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("decoded %0d bytes (%0d directed): %0d accepts, %0d rejects, %0d resyncs",
                 stream.size(), directed_n, sb.accepts, sb.rejects, sb.resyncs);
        $display("result side held off once for %0d cycles; %0d mismatches",
                 held_off, sb.errors);
        if (sb.errors == 0) begin
            $display("utf8_byte_decoder_tb: PASS");
        end else begin
            $display("utf8_byte_decoder_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/utf8d_pkg.sv
sv/utf8d_step.sv
sv/utf8_byte_decoder.sv
verif/utf8_byte_decoder_tb.sv
